### rtl/lkv_pkg.sv
package lkv_pkg;

    // Operation codes carried by an input item
    typedef enum logic [1:0] {
        CMD_GET_OR_CREATE = 2'd0,
        CMD_FIND          = 2'd1,
        CMD_DELETE        = 2'd2,
        CMD_ADD           = 2'd3
    } lkv_cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_CREATED   = 2'd3
    } lkv_status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_COMPARE = 2'd1,
        ST_ACT     = 2'd2
    } lkv_state_t;

    // Controls broadcast to every cell of the row
    typedef struct packed {
        logic compare_en;  // latch per-cell key match
        logic load_new;    // write the new pair into the tail cell
        logic shift;       // cells at or past the first match take their upper neighbor
    } lkv_ctl_t;

    // Fixed field widths of the stream items
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned FIELD_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned IN_W     = 72;
    localparam int unsigned OUT_W    = 40;

endpackage

### rtl/lkv_cell.sv
module lkv_cell
    import lkv_pkg::*;
#(
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  lkv_ctl_t              ctl,
    input  logic                  occupied,
    input  logic                  tail,
    input  logic [KEY_BITS-1:0]   key_in,
    input  logic [VALUE_BITS-1:0] value_in,
    input  logic [KEY_BITS-1:0]   upper_key,
    input  logic [VALUE_BITS-1:0] upper_value,
    input  logic                  found_in,
    input  logic [VALUE_BITS-1:0] chain_value_in,
    output logic                  found_out,
    output logic [VALUE_BITS-1:0] chain_value_out,
    output logic [KEY_BITS-1:0]   key_q,
    output logic [VALUE_BITS-1:0] value_q
);

    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  match_reg;

    // Latch the key compare for the item under way
    always_ff @(posedge clk)
    begin
        if (ctl.compare_en)
        begin
            match_reg <= occupied && (key_reg == key_in);
        end
    end

    // Pass the first-match flag and its value on to the next cell
    assign found_out       = found_in | match_reg;
    assign chain_value_out = (!found_in && match_reg) ? value_reg : chain_value_in;

    // Shift down to close a gap, or take the appended pair at the tail
    always_ff @(posedge clk)
    begin
        if (ctl.shift && found_out)
        begin
            key_reg   <= upper_key;
            value_reg <= upper_value;
        end
        else if (ctl.load_new && tail)
        begin
            key_reg   <= key_in;
            value_reg <= value_in;
        end
    end

    assign key_q   = key_reg;
    assign value_q = value_reg;

endmodule

### rtl/linear_key_value_table_core.sv
// An accepted item passes through the compare and act steps before its result is valid.
// The sequencer holds one item at a time and takes a new one only while idle; a result
//   waiting at the output stalls the act step and with it the next acceptance.
// The compare is parallel over the row of cells; first-match and shift run down the row.
// Reset (rst_n low, asynchronous) empties the table and clears the sequencer and output
//   valid; stored keys and values are not cleared and are only read below the fill count.
module linear_key_value_table_core
    import lkv_pkg::*;
#(
    parameter int unsigned CAPACITY   = 16,
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned VALUE_BITS = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // cmd[1:0], key[33:2], value[65:34], zero pad
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // value_out[31:0], status[33:32],
                                        // entry_count_out[38:34], zero pad
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    lkv_state_t              state_reg, state_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    lkv_cmd_t                cmd_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [VALUE_BITS-1:0]   value_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0]      out_value_reg, out_value_next;
    lkv_status_t             out_status_reg, out_status_next;
    logic [COUNT_W-1:0]      out_count_reg, out_count_next;

    lkv_ctl_t                ctl;
    logic [VALUE_BITS-1:0]   new_value;
    logic                    out_load;
    logic                    hit;
    logic                    full;

    logic [KEY_BITS+FIELD_W-1:0]   key_ext;
    logic [VALUE_BITS+FIELD_W-1:0] value_ext;
    logic [VALUE_BITS+FIELD_W-1:0] found_ext;
    logic [CNT_W+COUNT_W-1:0]      count_ext;

    logic [CAPACITY:0]                 found_c;
    logic [CAPACITY:0][VALUE_BITS-1:0] chain_c;
    logic [CAPACITY-1:0][KEY_BITS-1:0]   cell_key;
    logic [CAPACITY-1:0][VALUE_BITS-1:0] cell_value;
    logic [CAPACITY-1:0]               occupied;
    logic [CAPACITY-1:0]               tail;

    // Fit the fixed-width fields to the table widths
    assign key_ext   = {{KEY_BITS{1'b0}}, s_tdata[33:2]};
    assign value_ext = {{VALUE_BITS{1'b0}}, s_tdata[65:34]};
    assign found_ext = {{FIELD_W{1'b0}}, chain_c[CAPACITY]};

    // Row of cells with first-match and value chains
    assign found_c[0] = 1'b0;
    assign chain_c[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KEY_BITS-1:0]   upper_key;
        logic [VALUE_BITS-1:0] upper_value;

        if (i == CAPACITY - 1)
        begin : g_last
            assign upper_key   = '0;
            assign upper_value = '0;
        end
        else
        begin : g_mid
            assign upper_key   = cell_key[i+1];
            assign upper_value = cell_value[i+1];
        end

        assign occupied[i] = CNT_W'(i) < fill_reg;
        assign tail[i]     = fill_reg == CNT_W'(i);

        lkv_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk             (clk),
            .ctl             (ctl),
            .occupied        (occupied[i]),
            .tail            (tail[i]),
            .key_in          (key_reg),
            .value_in        (new_value),
            .upper_key       (upper_key),
            .upper_value     (upper_value),
            .found_in        (found_c[i]),
            .chain_value_in  (chain_c[i]),
            .found_out       (found_c[i+1]),
            .chain_value_out (chain_c[i+1]),
            .key_q           (cell_key[i]),
            .value_q         (cell_value[i])
        );
    end

    assign hit  = found_c[CAPACITY];
    assign full = fill_reg == CNT_W'(CAPACITY);

    // Next state, cell controls and result
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        out_valid_next  = out_valid_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        ctl             = '0;
        new_value       = '0;
        out_load        = 1'b0;
        count_ext       = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                ctl.compare_en = 1'b1;
                state_next     = ST_ACT;
            end
            ST_ACT:
            begin
                out_load = !out_valid_reg || m_tready;
                if (out_load)
                begin
                    out_value_next  = '0;
                    out_status_next = STAT_DONE;
                    case (cmd_reg)
                        CMD_GET_OR_CREATE:
                        begin
                            if (hit)
                            begin
                                out_value_next = found_ext[FIELD_W-1:0];
                            end
                            else if (full)
                            begin
                                out_status_next = STAT_FULL;
                            end
                            else
                            begin
                                ctl.load_new    = 1'b1;
                                fill_next       = fill_reg + CNT_W'(1);
                                out_status_next = STAT_CREATED;
                            end
                        end
                        CMD_FIND:
                        begin
                            if (hit)
                            begin
                                out_value_next = found_ext[FIELD_W-1:0];
                            end
                            else
                            begin
                                out_status_next = STAT_NOT_FOUND;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (hit)
                            begin
                                ctl.shift = 1'b1;
                                fill_next = fill_reg - CNT_W'(1);
                            end
                            else
                            begin
                                out_status_next = STAT_NOT_FOUND;
                            end
                        end
                        CMD_ADD:
                        begin
                            if (full)
                            begin
                                out_status_next = STAT_FULL;
                            end
                            else
                            begin
                                ctl.load_new = 1'b1;
                                new_value    = value_reg;
                                fill_next    = fill_reg + CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            out_status_next = STAT_NOT_FOUND;
                        end
                    endcase
                    count_ext      = {{COUNT_W{1'b0}}, fill_next};
                    out_count_next = count_ext[COUNT_W-1:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the accepted item and the result payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg   <= lkv_cmd_t'(s_tdata[1:0]);
            key_reg   <= key_ext[KEY_BITS-1:0];
            value_reg <= value_ext[VALUE_BITS-1:0];
        end
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_status_reg, out_value_reg};

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count exceeds capacity");

    a_result_from_act: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_ACT))
        else $error("result raised outside the act step");

    a_fill_changes_in_act: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |-> $past(state_reg == ST_ACT))
        else $error("fill count moved outside the act step");

    a_created_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_status_next == STAT_CREATED)
            |=> fill_reg == $past(fill_reg) + CNT_W'(1))
        else $error("created entry without count increment");

    a_found_needs_entries: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACT && hit) |-> fill_reg != '0)
        else $error("match reported in an empty table");
`endif

endmodule
